// ===== src/gelu_forward_backward_unit_defines.svh =====
// Assertion macros for the GELU forward/backward unit.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef GELU_FORWARD_BACKWARD_UNIT_DEFINES_SVH
`define GELU_FORWARD_BACKWARD_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that holds at every rising clock edge outside reset.
`define GFB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gfb check failed");
// Same-cycle implication outside reset.
`define GFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfb implication failed");
`else
`define GFB_ASSERT(label, clk, rst_n, prop)
`define GFB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/gfb_pkg.sv =====
// Shared constants, types and the tanh segment table for the GELU unit.
// No dependencies; every module and interface imports this package.
package gfb_pkg;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned TanhSegments = 256;
  localparam int unsigned DataW        = 24;
  localparam int unsigned NumStages    = 14;

  // Stage bases of the three datapath sections
  localparam int unsigned TanhBase = 0;
  localparam int unsigned GradBase = 6;
  localparam int unsigned OutBase  = 11;

  localparam int unsigned TabW  = FracBits + 1;        // tanh in [0,1]
  localparam int unsigned IdxW  = $clog2(TanhSegments);
  localparam int unsigned AcW   = FracBits + 4;        // |x| clamped to 8.0
  localparam int unsigned PolyW = FracBits + 4;        // 1 + 3c*x^2 below 10.0
  localparam int unsigned OpAW  = DataW + 1;
  localparam int unsigned OpBW  = AcW + PolyW - FracBits + 2;

  localparam logic [29:0] CSqrt2Pi = 30'd856722024;   // sqrt(2/pi) in Q30
  localparam logic [25:0] CCubic   = 26'd48012366;    // 0.044715 in Q30
  localparam logic [27:0] CCubic3  = 28'd144037098;   // 3*0.044715 in Q30

  localparam logic ModeFwd = 1'b0;
  localparam logic ModeBwd = 1'b1;

  localparam logic [TabW-1:0]  OneF       = TabW'(1) << FracBits;
  localparam logic [DataW-1:0] ResPosMax  = 24'h7FFFFF;
  localparam logic [DataW-1:0] ResNegMag  = 24'h800000;

  localparam logic [63:0] One30 = 64'd1 << 30;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } gfb_stage_ctl_t;

  typedef struct packed {
    logic                    mode;
    logic                    xneg;
    logic [DataW-1:0]        a;
    logic [AcW-1:0]          ac;
    logic [PolyW-1:0]        poly;
    logic signed [DataW-1:0] grad;
    logic [TabW-1:0]         t;
  } gfb_tanh_res_t;

  typedef struct packed {
    logic                   mode;
    logic                   xneg;
    logic signed [OpAW-1:0] op_a;
    logic signed [OpBW-1:0] op_b;
  } gfb_mul_op_t;

  // Restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q30 from a truncated Taylor series
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] term;
    longint      sum;
    term = One30;
    sum  = longint'(One30);
    for (int i = 1; i <= 20; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [TanhSegments:0][TabW-1:0] build_tanh_tab();
    logic [TanhSegments:0][TabW-1:0] tab;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] t30;
    tab = '0;
    for (int k = 0; k <= TanhSegments; k++) begin
      f = (64'(k) << 30) / TanhSegments;
      g = exp_neg_q30(f);
      if (g > One30) begin
        g = One30;
      end
      for (int j = 0; j < 3; j++) begin
        g = (g * g) >> 30;
      end
      t30    = udiv64((One30 - g) << 30, One30 + g);
      tab[k] = TabW'((t30 + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
    end
    return tab;
  endfunction

  localparam logic [TanhSegments:0][TabW-1:0]   TanhTab   = build_tanh_tab();
  localparam logic [TanhSegments-1:0][TabW-1:0] TanhLoTab = TanhTab[TanhSegments-1:0];
  localparam logic [TanhSegments-1:0][TabW-1:0] TanhHiTab = TanhTab[TanhSegments:1];

endpackage

// ===== src/gfb_if.sv =====
// Valid/ready channel interfaces for the GELU unit's input and result words.
// Depends on gfb_pkg for field widths.
interface gfb_in_if;
  import gfb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [DataW-1:0] act_in;
  logic signed [DataW-1:0] grad_in;
  modport source (output valid, mode, act_in, grad_in, input ready);
  modport sink (input valid, mode, act_in, grad_in, output ready);
endinterface

interface gfb_out_if;
  import gfb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_value;
  logic                    overflow;
  modport source (output valid, result_value, overflow, input ready);
  modport sink (input valid, result_value, overflow, output ready);
endinterface

// ===== src/gelu_forward_backward_unit.sv =====
// GELU forward value / backward gradient unit, tanh approximation, Q8.16.
// Pipeline of 14 register stages in three sections: tanh, grad and output.
// One word per cycle unless stalled; each stage holds one element, no loop-carried state.
// Stalls collapse bubbles: input is taken while any stage is empty or the output is ready.
// Reset (rst_ni, async, active low) clears the stage valid bits; the tanh table is constant.
`include "gelu_forward_backward_unit_defines.svh"

module gelu_forward_backward_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfb_in_if.sink    act_i,
  gfb_out_if.source res_o
);
  import gfb_pkg::*;

  gfb_stage_ctl_t stage_ctl;
  gfb_tanh_res_t  tanh_res;
  gfb_mul_op_t    mul_op;

  gfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (act_i.valid),
    .out_ready_i (res_o.ready),
    .ctl_o       (stage_ctl)
  );

  assign act_i.ready = stage_ctl.en[0];
  assign res_o.valid = stage_ctl.vld[NumStages-1];

  gfb_tanh u_tanh (
    .clk_i  (clk_i),
    .ctl_i  (stage_ctl),
    .mode_i (act_i.mode),
    .x_i    (act_i.act_in),
    .grad_i (act_i.grad_in),
    .res_o  (tanh_res)
  );

  gfb_grad u_grad (
    .clk_i  (clk_i),
    .ctl_i  (stage_ctl),
    .tanh_i (tanh_res),
    .mul_o  (mul_op)
  );

  gfb_out u_out (
    .clk_i      (clk_i),
    .ctl_i      (stage_ctl),
    .mul_i      (mul_op),
    .result_o   (res_o.result_value),
    .overflow_o (res_o.overflow)
  );

  // overflow only ever comes with one of the two clamp values
  `GFB_ASSERT_IMPL(ovf_clamped_a, clk_i, rst_ni, res_o.valid && res_o.overflow, (res_o.result_value == ResPosMax) || (res_o.result_value == ResNegMag))
  // interpolated tanh never exceeds one
  `GFB_ASSERT_IMPL(tanh_le_one_a, clk_i, rst_ni, stage_ctl.vld[GradBase-1], tanh_res.t <= OneF)
  // forward factor 1 +- t is never negative
  `GFB_ASSERT_IMPL(fwd_fac_pos_a, clk_i, rst_ni, stage_ctl.vld[OutBase-1] && (mul_op.mode == ModeFwd), !mul_op.op_b[OpBW-1])
  // an empty output stage always leaves room at the input
  `GFB_ASSERT(empty_out_ready_a, clk_i, rst_ni, res_o.valid || act_i.ready)

endmodule

// ===== src/gfb_ctrl.sv =====
// Pipeline valid bits and per-stage load enables with bubble collapsing.
// Depends on gfb_pkg.
module gfb_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    out_ready_i,
  output gfb_pkg::gfb_stage_ctl_t ctl_o
);
  import gfb_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vld_in;

  // A stage may load when the output drains or any stage from it onward is empty
  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&vld_q[NumStages-1:k]);
  end

  assign vld_in = {vld_q[NumStages-2:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_in[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

endmodule

// ===== src/gfb_tanh.sv =====
// Front section: |x| clamp, u = sqrt(2/pi)*(x+c*x^3), segment lookup and
// interpolation of tanh(u). Depends on gfb_pkg.
module gfb_tanh (
  input  logic                           clk_i,
  input  gfb_pkg::gfb_stage_ctl_t        ctl_i,
  input  logic                           mode_i,
  input  logic signed [gfb_pkg::DataW-1:0] x_i,
  input  logic signed [gfb_pkg::DataW-1:0] grad_i,
  output gfb_pkg::gfb_tanh_res_t         res_o
);
  import gfb_pkg::*;

  localparam int unsigned A2W    = FracBits + 7;
  localparam int unsigned A3W    = FracBits + 10;
  localparam int unsigned InnerW = FracBits + 5;
  localparam int unsigned RW     = FracBits + 2;
  localparam int unsigned SegW   = $clog2(TanhSegments + 1);
  localparam int unsigned PW     = InnerW + SegW;
  localparam int unsigned IxW    = PW - RW;
  localparam int unsigned SqW    = 2 * AcW;
  localparam int unsigned CubW   = A2W + AcW;
  localparam int unsigned PolyPW = A2W + 28;
  localparam int unsigned CcW    = A3W + 26;
  localparam int unsigned UpW    = InnerW + 30;
  localparam int unsigned IpW    = TabW + RW;

  localparam logic [AcW-1:0]   AcMax = AcW'(8) << FracBits;
  localparam logic [PolyW-1:0] OneP  = PolyW'(OneF);

  typedef struct packed {
    logic                    mode;
    logic                    xneg;
    logic [DataW-1:0]        a;
    logic [AcW-1:0]          ac;
    logic signed [DataW-1:0] grad;
  } carry_t;

  carry_t c_q [0:4];
  logic [PolyW-1:0] poly_q [1:4];

  // stage 0: magnitude, clamp, square
  logic [DataW-1:0] x_u;
  logic             xneg_d;
  logic [DataW-1:0] a_d;
  logic [AcW-1:0]   ac_d;
  logic [SqW-1:0]   sq_d;
  logic [A2W-1:0]   a2_q;

  assign x_u    = x_i;
  assign xneg_d = x_i[DataW-1];
  assign a_d    = xneg_d ? (~x_u + DataW'(1)) : x_u;
  assign ac_d   = (a_d > DataW'(AcMax)) ? AcMax : a_d[AcW-1:0];
  assign sq_d   = SqW'(ac_d) * SqW'(ac_d);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase]) begin
      c_q[0] <= '{mode: mode_i, xneg: xneg_d, a: a_d, ac: ac_d, grad: grad_i};
      a2_q   <= sq_d[FracBits +: A2W];
    end
  end

  // stage 1: cube and derivative polynomial
  logic [CubW-1:0]   cub_d;
  logic [PolyPW-1:0] polyp_d;
  logic [A3W-1:0]    a3_q;

  assign cub_d   = CubW'(a2_q) * CubW'(c_q[0].ac);
  assign polyp_d = PolyPW'(a2_q) * PolyPW'(CCubic3);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase+1]) begin
      c_q[1]    <= c_q[0];
      a3_q      <= cub_d[FracBits +: A3W];
      poly_q[1] <= OneP + polyp_d[30 +: PolyW];
    end
  end

  // stage 2: x + c*x^3
  logic [CcW-1:0]    cc_d;
  logic [InnerW-1:0] inner_q;

  assign cc_d = CcW'(a3_q) * CcW'(CCubic);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase+2]) begin
      c_q[2]    <= c_q[1];
      poly_q[2] <= poly_q[1];
      inner_q   <= InnerW'(c_q[1].ac) + cc_d[30 +: InnerW];
    end
  end

  // stage 3: scale by sqrt(2/pi)
  logic [UpW-1:0]    up_d;
  logic [InnerW-1:0] u_q;

  assign up_d = UpW'(inner_q) * UpW'(CSqrt2Pi);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase+3]) begin
      c_q[3]    <= c_q[2];
      poly_q[3] <= poly_q[2];
      u_q       <= up_d[30 +: InnerW];
    end
  end

  // stage 4: segment select and table read
  logic [PW-1:0]   p_d;
  logic [IxW-1:0]  ix_d;
  logic [IdxW-1:0] tix_d;
  logic            sat_d;
  logic [TabW-1:0] lo_d;
  logic [TabW-1:0] hi_d;
  logic [TabW-1:0] lo_q;
  logic [TabW-1:0] diff_q;
  logic [RW-1:0]   r_q;
  logic            sat_q;

  assign p_d   = PW'(u_q) * PW'(TanhSegments);
  assign ix_d  = p_d[PW-1:RW];
  assign tix_d = ix_d[IdxW-1:0];
  assign sat_d = ix_d >= IxW'(TanhSegments);
  assign lo_d  = TanhLoTab[tix_d];
  assign hi_d  = TanhHiTab[tix_d];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase+4]) begin
      c_q[4]    <= c_q[3];
      poly_q[4] <= poly_q[3];
      lo_q      <= lo_d;
      diff_q    <= (hi_d < lo_d) ? '0 : (hi_d - lo_d);
      r_q       <= p_d[RW-1:0];
      sat_q     <= sat_d;
    end
  end

  // stage 5: linear interpolation, saturate to one past the table
  logic [IpW-1:0]   ip_d;
  gfb_tanh_res_t    res_q;

  assign ip_d = IpW'(diff_q) * IpW'(r_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TanhBase+5]) begin
      res_q.mode <= c_q[4].mode;
      res_q.xneg <= c_q[4].xneg;
      res_q.a    <= c_q[4].a;
      res_q.ac   <= c_q[4].ac;
      res_q.grad <= c_q[4].grad;
      res_q.poly <= poly_q[4];
      res_q.t    <= sat_q ? OneF : (lo_q + ip_d[RW +: TabW]);
    end
  end

  assign res_o = res_q;

endmodule

// ===== src/gfb_grad.sv =====
// Middle section: derivative term w = sqrt(2/pi)*x*(1-t^2)*(1+3c*x^2) and
// multiplier operand select for both modes. Depends on gfb_pkg.
module gfb_grad (
  input  logic                    clk_i,
  input  gfb_pkg::gfb_stage_ctl_t ctl_i,
  input  gfb_pkg::gfb_tanh_res_t  tanh_i,
  output gfb_pkg::gfb_mul_op_t    mul_o
);
  import gfb_pkg::*;

  localparam int unsigned TtW  = 2 * TabW;
  localparam int unsigned W1PW = AcW + TabW;
  localparam int unsigned W2PW = AcW + 30;
  localparam int unsigned W3PW = AcW + PolyW;
  localparam int unsigned W3W  = AcW + PolyW - FracBits;
  localparam int unsigned DpW  = W3W + 1;
  localparam int unsigned FacW = TabW + 1;

  localparam logic [TtW-1:0]  OneSq = TtW'(1) << (2 * FracBits);
  localparam logic [OpBW-1:0] TwoF  = OpBW'(1) << (FracBits + 1);
  localparam logic [FacW-1:0] OneFac = FacW'(OneF);

  gfb_tanh_res_t r_q [0:3];

  // stage 0: 1 - t^2
  logic [TtW-1:0]  tt_d;
  logic [TtW-1:0]  sdiff_d;
  logic [TabW-1:0] s_q;

  assign tt_d    = TtW'(tanh_i.t) * TtW'(tanh_i.t);
  assign sdiff_d = OneSq - tt_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[GradBase]) begin
      r_q[0] <= tanh_i;
      s_q    <= sdiff_d[FracBits +: TabW];
    end
  end

  // stage 1: x*(1-t^2)
  logic [W1PW-1:0] w1p_d;
  logic [AcW-1:0]  w1_q;

  assign w1p_d = W1PW'(r_q[0].ac) * W1PW'(s_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[GradBase+1]) begin
      r_q[1] <= r_q[0];
      w1_q   <= w1p_d[FracBits +: AcW];
    end
  end

  // stage 2: times sqrt(2/pi)
  logic [W2PW-1:0] w2p_d;
  logic [AcW-1:0]  w2_q;

  assign w2p_d = W2PW'(w1_q) * W2PW'(CSqrt2Pi);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[GradBase+2]) begin
      r_q[2] <= r_q[1];
      w2_q   <= w2p_d[30 +: AcW];
    end
  end

  // stage 3: times the polynomial
  logic [W3PW-1:0] w3p_d;
  logic [W3W-1:0]  w3_q;

  assign w3p_d = W3PW'(w2_q) * W3PW'(r_q[2].poly);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[GradBase+3]) begin
      r_q[3] <= r_q[2];
      w3_q   <= w3p_d[FracBits +: W3W];
    end
  end

  // stage 4: twice the derivative, mirrored for negative x, and forward factor
  logic [DpW-1:0]  dp_d;
  logic [OpBW-1:0] d2_d;
  logic [FacW-1:0] fac_d;
  logic [OpAW-1:0] opa_d;
  logic [OpBW-1:0] opb_d;
  gfb_mul_op_t     mul_q;

  assign dp_d  = DpW'(OneF) + DpW'(r_q[3].t) + DpW'(w3_q);
  assign d2_d  = r_q[3].xneg ? (TwoF - OpBW'(dp_d)) : OpBW'(dp_d);
  assign fac_d = r_q[3].xneg ? (OneFac - FacW'(r_q[3].t)) : (OneFac + FacW'(r_q[3].t));

  always_comb begin
    if (r_q[3].mode == ModeBwd) begin
      opa_d = {r_q[3].grad[DataW-1], r_q[3].grad};
      opb_d = d2_d;
    end else begin
      opa_d = {1'b0, r_q[3].a};
      opb_d = OpBW'(fac_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[GradBase+4]) begin
      mul_q.mode <= r_q[3].mode;
      mul_q.xneg <= r_q[3].xneg;
      mul_q.op_a <= opa_d;
      mul_q.op_b <= opb_d;
    end
  end

  assign mul_o = mul_q;

endmodule

// ===== src/gfb_out.sv =====
// Back section: shared signed multiplier, round half away from zero at bit
// F+1, and 24-bit saturation with overflow flag. Depends on gfb_pkg.
module gfb_out (
  input  logic                             clk_i,
  input  gfb_pkg::gfb_stage_ctl_t          ctl_i,
  input  gfb_pkg::gfb_mul_op_t             mul_i,
  output logic signed [gfb_pkg::DataW-1:0] result_o,
  output logic                             overflow_o
);
  import gfb_pkg::*;

  localparam int unsigned ProdW = OpAW + OpBW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned MW    = SumW - (FracBits + 1);

  localparam logic [MW-1:0] PosLim = MW'(ResPosMax);
  localparam logic [MW-1:0] NegLim = MW'(ResNegMag);

  // stage 0: product
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic                    mode_q;
  logic                    xneg_q;

  assign prod_d = ProdW'(mul_i.op_a) * ProdW'(mul_i.op_b);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[OutBase]) begin
      prod_q <= prod_d;
      mode_q <= mul_i.mode;
      xneg_q <= mul_i.xneg;
    end
  end

  // stage 1: magnitude and rounding
  logic [ProdW-1:0] prod_u;
  logic             pneg_d;
  logic [ProdW-1:0] mag_d;
  logic [SumW-1:0]  sum_d;
  logic [MW-1:0]    m_q;
  logic             neg_q;

  assign prod_u = prod_q;
  assign pneg_d = prod_q[ProdW-1];
  assign mag_d  = pneg_d ? (~prod_u + ProdW'(1)) : prod_u;
  assign sum_d  = SumW'(mag_d) + SumW'(OneF);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[OutBase+1]) begin
      m_q   <= sum_d[SumW-1:FracBits+1];
      neg_q <= (mode_q == ModeBwd) ? pneg_d : xneg_q;
    end
  end

  // stage 2: clamp and restore sign
  logic             pos_ovf;
  logic             neg_ovf;
  logic [DataW-1:0] msel_d;
  logic [DataW-1:0] res_d;
  logic [DataW-1:0] res_q;
  logic             ovf_q;

  assign pos_ovf = !neg_q && (m_q > PosLim);
  assign neg_ovf = neg_q && (m_q > NegLim);

  always_comb begin
    if (pos_ovf) begin
      msel_d = ResPosMax;
    end else if (neg_ovf) begin
      msel_d = ResNegMag;
    end else begin
      msel_d = m_q[DataW-1:0];
    end
  end

  assign res_d = neg_q ? (~msel_d + DataW'(1)) : msel_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[OutBase+2]) begin
      res_q <= res_d;
      ovf_q <= pos_ovf | neg_ovf;
    end
  end

  assign result_o   = res_q;
  assign overflow_o = ovf_q;

endmodule
